### rtl/ctet_pkg.sv
package ctet_pkg;

  // default bracket nesting limit
  localparam int MAX_NESTING_DEF = 16;

  // characters with a special role
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  // result kinds
  localparam logic [2:0] KIND_NAME    = 3'd0;
  localparam logic [2:0] KIND_NEWARG  = 3'd1;
  localparam logic [2:0] KIND_ARG     = 3'd2;
  localparam logic [2:0] KIND_ACCEPT  = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // error codes
  localparam logic [1:0] ERR_SYMBOL     = 2'd0;
  localparam logic [1:0] ERR_MISMATCH   = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW   = 2'd2;
  localparam logic [1:0] ERR_INCOMPLETE = 2'd3;

  // parser states
  localparam logic [3:0] ST_WS1  = 4'd0;
  localparam logic [3:0] ST_NAME = 4'd1;
  localparam logic [3:0] ST_WS2  = 4'd2;
  localparam logic [3:0] ST_BRA  = 4'd3;
  localparam logic [3:0] ST_WS3  = 4'd4;
  localparam logic [3:0] ST_ARG  = 4'd5;
  localparam logic [3:0] ST_DQ   = 4'd6;
  localparam logic [3:0] ST_DQE  = 4'd7;
  localparam logic [3:0] ST_WS4  = 4'd8;
  localparam logic [3:0] ST_KOC  = 4'd9;
  localparam logic [3:0] ST_WS5  = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  // most results one character can cause
  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [1:0] code;
  } res_t;

  // all results of one character, entry 0 delivered first
  typedef struct packed {
    logic [1:0]         n;
    res_t [MAX_RES-1:0] r;
  } res_bundle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z") || (c == CH_UNDER) || (c == CH_MINUS);
  endfunction

endpackage

### rtl/ctet_stack_ram.sv
module ctet_stack_ram #(
  parameter int MAX_NESTING = ctet_pkg::MAX_NESTING_DEF,
  parameter int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data
);

  logic mem [MAX_NESTING];
  logic rd_q;
  logic fwd;
  logic fwd_data;

  // bracket kinds below the top of stack
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // same-cycle write to the address being read
  always_ff @(posedge clk) begin
    fwd      <= wr_en && (wr_addr == rd_addr);
    fwd_data <= wr_data;
  end

  assign rd_data = fwd ? fwd_data : rd_q;

endmodule

### rtl/ctet_parse.sv
module ctet_parse #(
  parameter int MAX_NESTING = ctet_pkg::MAX_NESTING_DEF,
  parameter int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1,
  parameter int DW = $clog2(MAX_NESTING + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           char_code,
  input  logic                 end_of_string,
  input  logic                 rd_data,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic                 wr_data,
  output logic [AW-1:0]        rd_addr,
  output ctet_pkg::res_bundle_t bundle
);

  import ctet_pkg::*;

  logic [3:0]    state;
  logic [DW-1:0] depth;
  logic          top;
  logic          keep_quotes;
  logic          arg_nonempty;
  logic          error_seen;

  logic [3:0]    state_next;
  logic [DW-1:0] depth_next;
  logic          top_next;
  logic          keep_quotes_next;
  logic          arg_nonempty_next;
  logic          error_seen_next;

  logic          push;
  logic          done;
  logic [1:0]    n;
  res_t [MAX_RES-1:0] r;
  logic [7:0]    want;
  logic [DW-1:0] wr_full;
  logic [DW-1:0] rd_full;

  // one character, re-examined after each state change
  always_comb begin
    state_next        = state;
    depth_next        = depth;
    top_next          = top;
    keep_quotes_next  = keep_quotes;
    arg_nonempty_next = arg_nonempty;
    error_seen_next   = error_seen;
    push              = 1'b0;
    done              = 1'b0;
    n                 = 2'd0;
    r                 = '0;
    want              = CH_RPAR;
    if (fire && !error_seen) begin
      for (int p = 0; p < 4; p++) begin
        if (!done) begin
          case (state_next)
            ST_WS1, ST_WS2, ST_WS3, ST_WS4, ST_WS5: begin
              if (is_space(char_code)) begin
                done = 1'b1;
              end else if (state_next == ST_WS1) begin
                state_next = ST_NAME;
              end else if (state_next == ST_WS2) begin
                state_next = ST_BRA;
              end else if (state_next == ST_WS3) begin
                r[n] = '{KIND_NEWARG, 8'd0, ERR_SYMBOL};
                n = n + 2'd1;
                arg_nonempty_next = 1'b0;
                state_next = ST_ARG;
              end else if (state_next == ST_WS4) begin
                state_next = ST_ARG;
              end else begin
                state_next = ST_DONE;
              end
            end
            ST_NAME: begin
              if (is_name_char(char_code)) begin
                r[n] = '{KIND_NAME, char_code, ERR_SYMBOL};
                n = n + 2'd1;
                done = 1'b1;
              end else begin
                state_next = ST_WS2;
              end
            end
            ST_BRA: begin
              if (char_code != CH_LPAR) begin
                r[n] = '{KIND_ERROR, 8'd0, ERR_SYMBOL};
                n = n + 2'd1;
                error_seen_next = 1'b1;
              end else begin
                state_next = ST_WS3;
              end
              done = 1'b1;
            end
            ST_ARG: begin
              if (is_space(char_code)) begin
                state_next = ST_WS4;
              end else if (char_code == CH_LPAR || char_code == CH_LBRACE) begin
                if (depth_next >= DW'(MAX_NESTING)) begin
                  r[n] = '{KIND_ERROR, 8'd0, ERR_OVERFLOW};
                  n = n + 2'd1;
                  error_seen_next = 1'b1;
                end else begin
                  push = 1'b1;
                  top_next = (char_code == CH_LBRACE);
                  depth_next = depth_next + DW'(1);
                  r[n] = '{KIND_ARG, char_code, ERR_SYMBOL};
                  n = n + 2'd1;
                  arg_nonempty_next = 1'b1;
                end
                done = 1'b1;
              end else if (char_code == CH_COMMA || char_code == CH_RPAR ||
                           char_code == CH_RBRACE) begin
                if (depth_next == '0) begin
                  state_next = ST_KOC;
                end else begin
                  want = top_next ? CH_RBRACE : CH_RPAR;
                  if (char_code != CH_COMMA && char_code != want) begin
                    r[n] = '{KIND_ERROR, 8'd0, ERR_MISMATCH};
                    n = n + 2'd1;
                    error_seen_next = 1'b1;
                  end else begin
                    if (char_code != CH_COMMA) begin
                      // pop: the entry below the top comes from memory
                      depth_next = depth_next - DW'(1);
                      top_next = rd_data;
                    end
                    r[n] = '{KIND_ARG, char_code, ERR_SYMBOL};
                    n = n + 2'd1;
                    arg_nonempty_next = 1'b1;
                  end
                  done = 1'b1;
                end
              end else if (char_code == CH_DQUOTE) begin
                keep_quotes_next = arg_nonempty_next;
                if (arg_nonempty_next) begin
                  r[n] = '{KIND_ARG, char_code, ERR_SYMBOL};
                  n = n + 2'd1;
                end
                state_next = ST_DQ;
                done = 1'b1;
              end else begin
                r[n] = '{KIND_ARG, char_code, ERR_SYMBOL};
                n = n + 2'd1;
                arg_nonempty_next = 1'b1;
                done = 1'b1;
              end
            end
            ST_DQ: begin
              if (char_code == CH_DQUOTE) begin
                if (keep_quotes_next) begin
                  r[n] = '{KIND_ARG, char_code, ERR_SYMBOL};
                  n = n + 2'd1;
                  arg_nonempty_next = 1'b1;
                end
                state_next = ST_ARG;
              end else if (char_code == CH_BSLASH) begin
                state_next = ST_DQE;
              end else begin
                r[n] = '{KIND_ARG, char_code, ERR_SYMBOL};
                n = n + 2'd1;
                arg_nonempty_next = 1'b1;
              end
              done = 1'b1;
            end
            ST_DQE: begin
              r[n] = '{KIND_ARG, char_code, ERR_SYMBOL};
              n = n + 2'd1;
              arg_nonempty_next = 1'b1;
              state_next = ST_DQ;
              done = 1'b1;
            end
            ST_KOC: begin
              if (char_code == CH_RPAR) begin
                state_next = ST_WS5;
              end else if (char_code == CH_COMMA) begin
                state_next = ST_WS3;
              end else begin
                r[n] = '{KIND_ERROR, 8'd0, ERR_SYMBOL};
                n = n + 2'd1;
                error_seen_next = 1'b1;
              end
              done = 1'b1;
            end
            default: begin
              r[n] = '{KIND_ERROR, 8'd0, ERR_SYMBOL};
              n = n + 2'd1;
              error_seen_next = 1'b1;
              done = 1'b1;
            end
          endcase
        end
      end
    end
    // end of string: verdict, then back to the reset state
    if (fire && end_of_string) begin
      if (!error_seen_next) begin
        if (state_next == ST_WS5) begin
          r[n] = '{KIND_ACCEPT, 8'd0, ERR_SYMBOL};
        end else begin
          r[n] = '{KIND_ERROR, 8'd0, ERR_INCOMPLETE};
        end
        n = n + 2'd1;
      end
      state_next        = ST_WS1;
      depth_next        = '0;
      keep_quotes_next  = 1'b0;
      arg_nonempty_next = 1'b0;
      error_seen_next   = 1'b0;
    end
  end

  // old top moves into memory on a push; read entry below the next top
  assign wr_full = depth - DW'(1);
  assign rd_full = depth_next - DW'(2);
  assign wr_en   = push && (depth != '0);
  assign wr_addr = wr_full[AW-1:0];
  assign wr_data = top;
  assign rd_addr = rd_full[AW-1:0];

  assign bundle.n = n;
  assign bundle.r = r;

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_WS1;
      depth        <= '0;
      keep_quotes  <= 1'b0;
      arg_nonempty <= 1'b0;
      error_seen   <= 1'b0;
    end else begin
      state        <= state_next;
      depth        <= depth_next;
      keep_quotes  <= keep_quotes_next;
      arg_nonempty <= arg_nonempty_next;
      error_seen   <= error_seen_next;
    end
  end

  // top of stack, only meaningful while depth is nonzero
  always_ff @(posedge clk) begin
    top <= top_next;
  end

endmodule

### rtl/ctet_obuf.sv
module ctet_obuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  ctet_pkg::res_bundle_t bundle,
  output logic                  in_ready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,
  output logic [2:0]            m_tuser,
  output logic                  m_tlast
);

  import ctet_pkg::*;

  res_t [MAX_RES-1:0] slots;
  logic [1:0]         cnt;
  logic               take;

  assign take     = m_tvalid && m_tready;
  assign in_ready = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);

  // results in order, head in slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= bundle.n;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= bundle.r;
    end else if (take) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = {6'd0, slots[0].code, slots[0].ch};
  assign m_tuser  = slots[0].kind;
  assign m_tlast  = (cnt == 2'd1);

endmodule

### rtl/call_expression_tokenizer_core.sv
// channel  dir  signals                          transaction
// s_*      in   tdata: char_code[7:0]            one character of the string
//               tlast: end_of_string
// m_*      out  tdata: out_char[7:0],            one token result
//               error_code[9:8]; tuser: kind;
//               tlast: last result of a character
//
// a character that causes several results holds the input while the
// three-entry result buffer drains, and the next is taken as the last leaves.
// the bracket stack top sits in a register, the rest in a small memory
// that is read ahead through a registered port at the entry below the top,
// so pops and pushes go back to back.
// rst is synchronous and clears the parser state and the result buffer.
// a stalled output holds the input as long as any result waits in the buffer.
module call_expression_tokenizer_core #(
  parameter int MAX_NESTING = ctet_pkg::MAX_NESTING_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_char[7:0], error_code[9:8], zero[15:10]
  output logic [2:0]  m_tuser,   // kind[2:0]
  output logic        m_tlast
);

  import ctet_pkg::*;

  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  logic          fire;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_data;
  logic [AW-1:0] rd_addr;
  logic          rd_data;
  res_bundle_t   bundle;

  assign fire = s_tvalid && s_tready;

  ctet_stack_ram #(
    .MAX_NESTING(MAX_NESTING)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ctet_parse #(
    .MAX_NESTING(MAX_NESTING)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .char_code    (s_tdata),
    .end_of_string(s_tlast),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .bundle       (bundle)
  );

  ctet_obuf u_obuf (
    .clk     (clk),
    .rst     (rst),
    .load    (fire),
    .bundle  (bundle),
    .in_ready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule
